[src/jase_pkg.sv]
// Shared types and constants for the JPEG APP segment extractor.
package jase_pkg;

  localparam logic [7:0] MARK_START = 8'hFF;
  localparam logic [7:0] APP_MASK   = 8'hF0;
  localparam logic [7:0] APP_BASE   = 8'hE0;
  localparam logic [7:0] APP_EXIF   = 8'hE1;
  localparam logic [7:0] APP_ICC    = 8'hE2;
  localparam logic [7:0] APP_IPTC   = 8'hED;

  localparam logic [1:0] KIND_EXIF = 2'd0;
  localparam logic [1:0] KIND_ICC  = 2'd1;
  localparam logic [1:0] KIND_IPTC = 2'd2;

  localparam logic [2:0] ALL_CAPTURED = 3'b111;

  typedef enum logic [6:0] {
    PH_START   = 7'b0000001,
    PH_MARKER  = 7'b0000010,
    PH_LEN_HI  = 7'b0000100,
    PH_LEN_LO  = 7'b0001000,
    PH_SKIP    = 7'b0010000,
    PH_CAPTURE = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic        byte_valid;
    logic [1:0]  segment_kind;
    logic [7:0]  payload_byte;
    logic        first_of_segment;
    logic        last_of_segment;
    logic [15:0] segment_length;
    logic        finished;
  } result_t;

endpackage

[src/jase_parser.sv]
// Marker/segment parse state and the per-byte result logic.
module jase_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  output jase_pkg::result_t  result
);
  import jase_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] payload_total, payload_total_next;
  logic [7:0]  marker_code, marker_code_next;
  logic [2:0]  captured_flags, captured_flags_next;
  logic [1:0]  current_kind, current_kind_next;

  logic [15:0] len;
  logic [15:0] pay;
  logic [15:0] left_dec;
  logic        kind_hit;
  logic [1:0]  kind_sel;

  assign len      = bytes_left | {8'h00, data_byte};
  assign pay      = (len >= 16'd2) ? len - 16'd2 : 16'd0;
  assign left_dec = (bytes_left != 16'd0) ? bytes_left - 16'd1 : 16'd0;

  always_comb begin
    kind_hit = 1'b1;
    kind_sel = KIND_EXIF;
    unique case (marker_code)
      APP_EXIF: kind_sel = KIND_EXIF;
      APP_ICC:  kind_sel = KIND_ICC;
      APP_IPTC: kind_sel = KIND_IPTC;
      default:  kind_hit = 1'b0;
    endcase
  end

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    payload_total_next  = payload_total;
    marker_code_next    = marker_code;
    captured_flags_next = captured_flags;
    current_kind_next   = current_kind;
    result              = '0;
    unique case (phase)
      PH_START: begin
        phase_next = (data_byte == MARK_START) ? PH_MARKER : PH_DONE;
      end
      PH_MARKER: begin
        if ((data_byte & APP_MASK) == APP_BASE) begin
          marker_code_next = data_byte;
          bytes_left_next  = 16'd0;
          phase_next       = PH_LEN_HI;
        end else begin
          phase_next = PH_START;
        end
      end
      PH_LEN_HI: begin
        bytes_left_next = {data_byte, 8'h00};
        phase_next      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        bytes_left_next    = pay;
        payload_total_next = pay;
        marker_code_next   = 8'h00;
        if (pay == 16'd0) begin
          phase_next = PH_START;
        end else if (kind_hit && !captured_flags[kind_sel]) begin
          captured_flags_next           = captured_flags;
          captured_flags_next[kind_sel] = 1'b1;
          current_kind_next             = kind_sel;
          phase_next                    = PH_CAPTURE;
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        bytes_left_next = left_dec;
        if (left_dec == 16'd0) phase_next = PH_START;
      end
      PH_CAPTURE: begin
        result.byte_valid       = 1'b1;
        result.segment_kind     = current_kind;
        result.payload_byte     = data_byte;
        result.segment_length   = payload_total;
        result.first_of_segment = (bytes_left == payload_total);
        result.last_of_segment  = (bytes_left <= 16'd1);
        bytes_left_next         = left_dec;
        if (left_dec == 16'd0) begin
          phase_next = (captured_flags == ALL_CAPTURED) ? PH_DONE : PH_START;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
    result.finished = (phase_next == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      bytes_left     <= 16'd0;
      payload_total  <= 16'd0;
      marker_code    <= 8'h00;
      captured_flags <= 3'b000;
      current_kind   <= KIND_EXIF;
    end else if (accept) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      payload_total  <= payload_total_next;
      marker_code    <= marker_code_next;
      captured_flags <= captured_flags_next;
      current_kind   <= current_kind_next;
    end
  end

endmodule

[src/jpeg_app_segment_extractor_core.sv]
// Top level: JPEG APP1/APP2/APP13 payload extractor with output register and skid stage.
// Accepted beats' results are registered in the output stage, or skid stage if stalled.
// One byte per cycle unless in_stall is high; parse state steps on each accepted byte.
// A skid stage lets one more beat in while the output beat is stalled.
// Reset (rst, synchronous): parser returns to expecting 0xFF, no segments captured,
// output and skid stages empty.
module jpeg_app_segment_extractor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        byte_valid,
  output logic [1:0]  segment_kind,
  output logic [7:0]  payload_byte,
  output logic        first_of_segment,
  output logic        last_of_segment,
  output logic [15:0] segment_length,
  output logic        finished
);
  import jase_pkg::*;

  result_t step_res;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    accept;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;

  jase_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      // output held; park a new beat in the skid stage
      if (accept) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (accept) skid_res <= step_res;
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (accept) begin
      out_res <= step_res;
    end
  end

  assign byte_valid       = out_res.byte_valid;
  assign segment_kind     = out_res.segment_kind;
  assign payload_byte     = out_res.payload_byte;
  assign first_of_segment = out_res.first_of_segment;
  assign last_of_segment  = out_res.last_of_segment;
  assign segment_length   = out_res.segment_length;
  assign finished         = out_res.finished;

endmodule

[verif/jpeg_app_segment_extractor_core_test.sv]
// Testbench for the JPEG APP segment extractor: builds a byte stream, predicts and checks results.
`timescale 1ns / 1ps

module jpeg_app_segment_extractor_core_test;
  import jase_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BYTES = 900;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        byte_valid;
  logic [1:0]  segment_kind;
  logic [7:0]  payload_byte;
  logic        first_of_segment;
  logic        last_of_segment;
  logic [15:0] segment_length;
  logic        finished;

  jpeg_app_segment_extractor_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .byte_valid(byte_valid),
    .segment_kind(segment_kind),
    .payload_byte(payload_byte),
    .first_of_segment(first_of_segment),
    .last_of_segment(last_of_segment),
    .segment_length(segment_length),
    .finished(finished)
  );

  // Parser state mirror
  phase_t      parse_state = PH_START;
  logic [15:0] bytes_left = '0;
  logic [15:0] payload_total = '0;
  logic [7:0]  marker_code = '0;
  logic [2:0]  kinds_seen = '0;
  logic [1:0]  active_kind = '0;

  logic [7:0] file_bytes[$];
  result_t    expected_results[$];
  result_t    predicted_beat;
  result_t    want;
  int         stream_length = 0;
  int         beats_sent = 0;
  int         results_seen = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         captured_per_kind[3] = '{0, 0, 0};
  bit         end_by_capture;
  logic [7:0] held_code;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic parse_byte(input logic [7:0] b, output result_t r);
    logic [15:0] len_word;
    logic [15:0] pay;
    logic [1:0]  k;
    bit          known;
    r = '0;
    k = KIND_EXIF;
    known = 1'b1;
    case (parse_state)
      PH_START: parse_state = (b == MARK_START) ? PH_MARKER : PH_DONE;
      PH_MARKER: begin
        if ((b & APP_MASK) == APP_BASE) begin
          marker_code = b;
          bytes_left = '0;
          parse_state = PH_LEN_HI;
        end else begin
          parse_state = PH_START;
        end
      end
      PH_LEN_HI: begin
        bytes_left = {b, 8'h00};
        parse_state = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_word = bytes_left | {8'h00, b};
        pay = (len_word >= 16'd2) ? len_word - 16'd2 : 16'd0;
        if (marker_code == APP_EXIF) k = KIND_EXIF;
        else if (marker_code == APP_ICC) k = KIND_ICC;
        else if (marker_code == APP_IPTC) k = KIND_IPTC;
        else known = 1'b0;
        bytes_left = pay;
        payload_total = pay;
        if (pay == 16'd0) begin
          parse_state = PH_START;
        end else if (known && !kinds_seen[k]) begin
          kinds_seen[k] = 1'b1;
          active_kind = k;
          parse_state = PH_CAPTURE;
        end else begin
          parse_state = PH_SKIP;
        end
        marker_code = '0;
      end
      PH_SKIP: begin
        if (bytes_left != 16'd0) bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) parse_state = PH_START;
      end
      PH_CAPTURE: begin
        r.byte_valid = 1'b1;
        r.segment_kind = active_kind;
        r.payload_byte = b;
        r.segment_length = payload_total;
        r.first_of_segment = (bytes_left == payload_total);
        r.last_of_segment = (bytes_left <= 16'd1);
        if (bytes_left != 16'd0) bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0)
          parse_state = (kinds_seen == ALL_CAPTURED) ? PH_DONE : PH_START;
      end
      default: parse_state = PH_DONE;
    endcase
    r.finished = (parse_state == PH_DONE);
  endtask

  // APPn segment: marker, big-endian length, then length-2 random payload bytes
  task automatic put_app(input logic [7:0] code, input logic [15:0] len_field);
    int n;
    n = (len_field >= 16'd2) ? len_field - 2 : 0;
    file_bytes.push_back(MARK_START);
    file_bytes.push_back(code);
    file_bytes.push_back(len_field[15:8]);
    file_bytes.push_back(len_field[7:0]);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // stage 0: sender 37% idle, receiver 53%; stage 1 swapped; stage 2 no idling
  function automatic int idle_pct(int beats, bit is_receiver);
    int stage = (stream_length == 0) ? 0 : beats * 3 / stream_length;
    if (stage >= 2) return 0;
    return ((stage == 0) ^ is_receiver) ? 37 : 53;
  endfunction

  task automatic build_stream();
    int pick;
    logic [7:0] code;
    logic [15:0] len_field;
    // directed: fill byte, short lengths, one-byte Exif, repeated Exif
    file_bytes.push_back(MARK_START);
    file_bytes.push_back(MARK_START);
    put_app(APP_EXIF, 16'd0);
    put_app(APP_ICC, 16'd1);
    put_app(APP_IPTC, 16'd2);
    file_bytes.push_back(MARK_START);
    file_bytes.push_back(APP_EXIF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h03);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(MARK_START);
    file_bytes.push_back(APP_EXIF);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'h04);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h80);

    // one kind is held back so parsing cannot finish before the planned end
    held_code = $urandom_range(0, 1) ? APP_ICC : APP_IPTC;
    end_by_capture = 1'($urandom_range(0, 1));
    while (file_bytes.size() < 25 + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        do code = 8'($urandom_range(0, 255));
        while ((code & APP_MASK) == APP_BASE);
        file_bytes.push_back(MARK_START);
        file_bytes.push_back(code);
      end else if (pick < 25) begin
        put_app(APP_BASE | 8'($urandom_range(0, 15)), 16'($urandom_range(0, 2)));
      end else begin
        case ($urandom_range(0, 3))
          0: code = APP_EXIF;
          1: code = APP_ICC;
          2: code = APP_IPTC;
          default: code = APP_BASE | 8'($urandom_range(0, 15));
        endcase
        if ($urandom_range(0, 19) == 0) len_field = 16'($urandom_range(16'h0100, 16'h01FF));
        else len_field = 16'($urandom_range(3, 40));
        if (code == held_code) len_field = 16'($urandom_range(0, 2));
        put_app(code, len_field);
      end
    end

    if (end_by_capture) begin
      // make sure the other kind is in before the held one closes the set
      put_app((held_code == APP_ICC) ? APP_IPTC : APP_ICC, 16'($urandom_range(3, 40)));
      put_app(held_code, 16'($urandom_range(3, 40)));
    end else begin
      put_app(APP_BASE, 16'($urandom_range(3, 40)));
      file_bytes.push_back(8'($urandom_range(0, 254)));
    end
    // ignored once parsing has stopped
    repeat (16) file_bytes.push_back(8'($urandom_range(0, 255)));
    stream_length = file_bytes.size();
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        parse_byte(data_byte, predicted_beat);
        expected_results.push_back(predicted_beat);
        beats_sent++;
      end
      if (file_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct(beats_sent, 1'b0)) begin
        in_valid <= 1'b1;
        data_byte <= file_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result beat with no input pending");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (byte_valid && segment_kind < 2'd3) captured_per_kind[segment_kind]++;
          if (byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0d, got %0d", want.byte_valid, byte_valid);
            mismatch_count++;
          end
          if (segment_kind !== want.segment_kind) begin
            $error("segment_kind: expected %0d, got %0d", want.segment_kind, segment_kind);
            mismatch_count++;
          end
          if (payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %02h, got %02h", want.payload_byte, payload_byte);
            mismatch_count++;
          end
          if (first_of_segment !== want.first_of_segment) begin
            $error("first_of_segment: expected %0d, got %0d",
                   want.first_of_segment, first_of_segment);
            mismatch_count++;
          end
          if (last_of_segment !== want.last_of_segment) begin
            $error("last_of_segment: expected %0d, got %0d",
                   want.last_of_segment, last_of_segment);
            mismatch_count++;
          end
          if (segment_length !== want.segment_length) begin
            $error("segment_length: expected %0d, got %0d",
                   want.segment_length, segment_length);
            mismatch_count++;
          end
          if (finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, finished);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < idle_pct(results_seen, 1'b1));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("jpeg_app_segment_extractor_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    build_stream();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (file_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("%0d file bytes checked; payload beats Exif %0d, ICC %0d, IPTC %0d",
             beats_sent, captured_per_kind[0], captured_per_kind[1], captured_per_kind[2]);
    $display("stream stopped by %s", end_by_capture ? "the third full capture"
                                                    : "a bad start byte");
    if (mismatch_count == 0) begin
      $display("jpeg_app_segment_extractor_core_test: done, clean");
    end else begin
      $display("jpeg_app_segment_extractor_core_test: done, errors");
    end
    $finish;
  end

endmodule
